>>> hw/rtl/trm_pkg.sv
// Shared types and constants for the ternary rule match block.
`default_nettype none

package trm_pkg;

  // Fixed field widths of the request and result words
  localparam int FieldW = 32;
  localparam int SlotW  = 4;
  // Width used to compare slot numbers against row numbers (rows up to 255)
  localparam int RowW   = 8;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [SlotW-1:0]  slot_index;
    logic              slot_enable;
    logic [FieldW-1:0] rule_value_bits;
    logic [FieldW-1:0] rule_care_bits;
    logic [FieldW-1:0] lookup_key;
  } request_t;

  typedef struct packed {
    logic [SlotW-1:0] match_index;
    logic             match_found;
    logic             last_result;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic write;
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/trm_ctrl.sv
// Controller state machine of the ternary rule match block.
`default_nettype none

module trm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  trm_pkg::cmd_t       command,
  input  trm_pkg::dp_status_t status,
  output logic                busy,
  output trm_pkg::dp_cmd_t    cmd
);
  import trm_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == CMD_LOOKUP) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    cmd.write = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.write = accept && (command == CMD_WRITE);
        cmd.load  = accept && (command == CMD_LOOKUP);
      end
      ST_EMIT: begin
        busy     = 1'b1;
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/trm_datapath.sv
// Rule table, parallel compare, hit vector and result register.
`default_nettype none

module trm_datapath #(
  parameter int NUM_RULES = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  trm_pkg::dp_cmd_t    cmd,
  input  trm_pkg::request_t   request,
  output trm_pkg::dp_status_t status,
  output logic                strobe,
  output trm_pkg::result_t    result
);
  import trm_pkg::*;

  // Words never exceed the request field width
  localparam int StoreW = (KEY_WIDTH < FieldW) ? KEY_WIDTH : FieldW;

  logic [StoreW-1:0]    value_store [NUM_RULES];
  logic [StoreW-1:0]    care_store  [NUM_RULES];
  logic [NUM_RULES-1:0] slot_valid;
  logic [NUM_RULES-1:0] row_hit;
  logic [NUM_RULES-1:0] hit_vec;
  logic [NUM_RULES-1:0] hit_rest;
  logic [StoreW-1:0]    key;
  logic [RowW-1:0]      slot_wide;
  logic [RowW-1:0]      first_idx;
  logic                 any_hit;

  assign key       = request.lookup_key[StoreW-1:0];
  assign slot_wide = RowW'(request.slot_index);

  for (genvar i = 0; i < NUM_RULES; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (cmd.write && slot_wide == RowW'(i)) begin
        value_store[i] <= request.rule_value_bits[StoreW-1:0];
        care_store[i]  <= request.rule_care_bits[StoreW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        slot_valid[i] <= 1'b0;
      end else if (cmd.write && slot_wide == RowW'(i)) begin
        slot_valid[i] <= request.slot_enable;
      end
    end

    assign row_hit[i] = slot_valid[i] && ((key & care_store[i]) == value_store[i]);
  end

  // Lowest pending hit
  always_comb begin
    first_idx = '0;
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        first_idx = RowW'(i);
      end
    end
  end

  assign hit_rest    = hit_vec & (hit_vec - NUM_RULES'(1));
  assign any_hit     = |hit_vec;
  assign status.last = (hit_rest == '0);

  // Capture all hits at once, then drop the lowest one per emitted result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_vec <= row_hit;
    end else if (cmd.emit) begin
      hit_vec <= hit_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.match_index <= first_idx[SlotW-1:0];
      result.match_found <= any_hit;
      result.last_result <= status.last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ternary_rule_match.sv
// Top level of the ternary rule match block.
`default_nettype none

// Ternary rule match: a table of NUM_RULES rules, each a value word and a care
// mask, searched by key. A request is taken at a rising edge with start high
// and busy low. A write request (command CMD_WRITE) stores value and care into
// slot_index and sets that slot valid from slot_enable; it produces no result, and
// a slot at or above NUM_RULES is ignored. A lookup
// request compares the key against every rule in parallel at the accepting
// edge, then emits one result per cycle, lowest matching slot first, with
// last_result on the final one; a lookup with no match gives a single result
// with match_found clear. Results come from a register and are marked by strobe
// for exactly one cycle each. The receiver cannot stall, so it must take every
// strobed result. Busy is high while results are still being emitted. The next
// request can be accepted in the same cycle that the last result of a lookup is
// on the port.
module ternary_rule_match #(
  parameter int NUM_RULES = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  trm_pkg::request_t request,
  output logic              strobe,
  output trm_pkg::result_t  result
);
  import trm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence accept, compare and emit
  trm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Hold the rules, compare the key, advance through the hits
  trm_datapath #(
    .NUM_RULES (NUM_RULES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

`default_nettype wire

>>> hw/rtl/trm_checker.sv
// Port-level checker for the ternary rule match block and its bind.
`default_nettype none

module trm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input trm_pkg::request_t request,
  input logic              strobe,
  input trm_pkg::result_t  result
);
  import trm_pkg::*;

  // An accepted lookup always occupies the block in the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == CMD_LOOKUP |=> busy)
    else $error("lookup accepted but block not busy next cycle");

  // Results of one lookup arrive back to back until the last one
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_result |=> strobe)
    else $error("gap inside a result burst");

  // A no-match result is always the only and last one
  a_nomatch_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.match_found |-> result.last_result)
    else $error("no-match result not marked last");

  // Busy falls exactly when the last result is shown
  a_busy_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (busy == !result.last_result))
    else $error("busy does not track the result burst");

endmodule

bind ternary_rule_match trm_checker u_trm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);

`default_nettype wire

>>> tb/sv/tb_ternary_rule_match.sv
// Self-checking testbench for the ternary rule match block.
module tb_ternary_rule_match;
  import trm_pkg::*;

  localparam int RULES       = 16;
  localparam int KEYW        = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     strobe;
  result_t  result;

  ternary_rule_match #(
    .NUM_RULES(RULES),
    .KEY_WIDTH(KEYW)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  // Shadow copy of the rule table, updated as each request is taken
  logic [FieldW-1:0] rule_value [RULES];
  logic [FieldW-1:0] rule_care  [RULES];
  bit                rule_live  [RULES];

  // Match results still owed by the block, oldest first
  result_t pending_matches [$];
  result_t want;
  int      errors = 0;
  int      cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ternary_rule_match");
      $finish;
    end
  end

  // Compare every strobed result with the oldest owed one
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, result);
      end else begin
        want = pending_matches.pop_front();
        if (result.match_index !== want.match_index) begin
          errors++;
          $display("%0t: match_index mismatch: expected %0d, actual %0d",
                   $time, want.match_index, result.match_index);
        end
        if (result.match_found !== want.match_found) begin
          errors++;
          $display("%0t: match_found mismatch: expected %0b, actual %0b",
                   $time, want.match_found, result.match_found);
        end
        if (result.last_result !== want.last_result) begin
          errors++;
          $display("%0t: last_result mismatch: expected %0b, actual %0b",
                   $time, want.last_result, result.last_result);
        end
      end
    end
  end

  // Update the shadow table for a write, or owe the hits of a lookup
  task automatic apply_request(input request_t req);
    result_t hit;
    int      hits;
    hits = 0;
    if (req.command == CMD_WRITE) begin
      // slots past the table are dropped
      if (int'(req.slot_index) < RULES) begin
        rule_value[req.slot_index] = req.rule_value_bits;
        rule_care[req.slot_index]  = req.rule_care_bits;
        rule_live[req.slot_index]  = req.slot_enable;
      end
    end else begin
      for (int i = 0; i < RULES; i++) begin
        if (rule_live[i] && ((req.lookup_key & rule_care[i]) == rule_value[i])) begin
          hit.match_index = SlotW'(i);
          hit.match_found = 1'b1;
          hit.last_result = 1'b0;
          pending_matches.insert(pending_matches.size(), hit);
          hits++;
        end
      end
      if (hits == 0) begin
        hit.match_index = '0;
        hit.match_found = 1'b0;
        hit.last_result = 1'b1;
        pending_matches.insert(pending_matches.size(), hit);
      end else begin
        pending_matches[pending_matches.size()-1].last_result = 1'b1;
      end
    end
  endtask

  // Idle at random, then hold the request until the block takes it
  task automatic send_request(input request_t req, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    apply_request(req);
  endtask

  // Hold off new requests until every owed result has come back
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  // Fill the fields a command ignores with noise
  function automatic request_t write_req(input int slot, input bit enable,
                                         input logic [FieldW-1:0] value,
                                         input logic [FieldW-1:0] care);
    request_t req;
    req.command         = CMD_WRITE;
    req.slot_index      = SlotW'(slot);
    req.slot_enable     = enable;
    req.rule_value_bits = value;
    req.rule_care_bits  = care;
    req.lookup_key      = $urandom;
    return req;
  endfunction

  function automatic request_t lookup_req(input logic [FieldW-1:0] key);
    request_t req;
    req.command         = CMD_LOOKUP;
    req.slot_index      = SlotW'($urandom);
    req.slot_enable     = 1'($urandom_range(1));
    req.rule_value_bits = $urandom;
    req.rule_care_bits  = $urandom;
    req.lookup_key      = key;
    return req;
  endfunction

  // Mix of care densities so that rules both hit and miss
  function automatic logic [FieldW-1:0] random_care();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom & $urandom & $urandom;
      4, 5:    return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_request(lookup_req('0), 18);
    send_request(lookup_req('1), 18);
  endtask

  // Match-all rule in the first slot, exact all-ones rule in the last
  task automatic test_first_and_last_slot();
    send_request(write_req(0, 1'b1, '0, '0), 18);
    send_request(write_req(RULES - 1, 1'b1, '1, '1), 18);
    send_request(lookup_req('1), 18);
  endtask

  // Every slot hits: longest possible burst of results
  task automatic test_full_table();
    for (int s = 1; s < RULES - 1; s++) send_request(write_req(s, 1'b1, '0, '0), 18);
    send_request(lookup_req('1), 18);
  endtask

  // A value bit where care is clear makes the rule dead
  task automatic test_value_outside_care();
    send_request(write_req(7, 1'b1, 32'h0000_0001, '0), 18);
    send_request(lookup_req('1), 18);
  endtask

  task automatic test_slot_clear();
    send_request(write_req(0, 1'b0, '0, '0), 18);
    send_request(lookup_req('0), 18);
  endtask

  // Mostly lookups aimed at live rules, with writes and wild keys mixed in
  task automatic test_random_traffic(input int count, input int idle_pct);
    logic [FieldW-1:0] care;
    logic [FieldW-1:0] value;
    logic [FieldW-1:0] key;
    int                live [$];
    int                s;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 35) begin
        care  = random_care();
        value = ($urandom_range(99) < 85) ? ($urandom & care) : $urandom;
        send_request(write_req($urandom_range(RULES - 1), $urandom_range(99) < 85,
                               value, care), idle_pct);
      end else begin
        live.delete();
        for (int i = 0; i < RULES; i++) if (rule_live[i]) live.insert(live.size(), i);
        if (live.size() > 0 && $urandom_range(99) < 75) begin
          s   = live[$urandom_range(live.size() - 1)];
          key = (rule_value[s] & rule_care[s]) | ($urandom & ~rule_care[s]);
        end else begin
          case ($urandom_range(9))
            0:       key = '0;
            1:       key = '1;
            default: key = $urandom;
          endcase
        end
        send_request(lookup_req(key), idle_pct);
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    for (int i = 0; i < RULES; i++) begin
      rule_value[i] = '0;
      rule_care[i]  = '0;
      rule_live[i]  = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_first_and_last_slot();
    test_full_table();
    test_value_outside_care();
    test_slot_clear();
    wait_for_drain();

    test_random_traffic(120, 18);
    wait_for_drain();
    test_random_traffic(120, 86);
    wait_for_drain();
    test_random_traffic(120, 0);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS ternary_rule_match");
    end else begin
      $display("FAIL ternary_rule_match");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/trm_pkg.sv
hw/rtl/trm_ctrl.sv
hw/rtl/trm_datapath.sv
hw/rtl/ternary_rule_match.sv
hw/rtl/trm_checker.sv
tb/sv/tb_ternary_rule_match.sv
